// ----- src/lphi_pkg.sv -----
// Package for the linear-probing hash insert block.
// Holds parameter defaults, register indexes and fixed constants; no dependencies.
package lphi_pkg;
	localparam int MAX_SLOTS_DEF = 1024;
	localparam int KEY_BITS_DEF = 31;
	localparam int ADDR_W = 3;
	localparam logic REG_INIT_SIZE = 1'b0;
	localparam logic REG_LOAD_PCT = 1'b1;
	localparam logic [7:0] INIT_SIZE_RST = 8'd1;
	localparam logic [6:0] LOAD_PCT_RST = 7'd70;
	localparam logic [6:0] LOAD_SCALE = 7'd100;
	localparam logic STATUS_STORED = 1'b0;
	localparam logic STATUS_FULL = 1'b1;
endpackage

// ----- src/linear_probe_hash_insert_rehash.sv -----
// Top level of the open-addressing hash table with linear probing and rehash growth.
// Depends on lphi_pkg; holds both key banks as synchronous memories.

// Each item inserts one key and returns one result item. The home slot is set by the
// bit-serial remainder unit that computes key mod capacity, and the probe then walks
// past each occupied slot, reading and checking each in turn. When the load test
// triggers growth, a trial-division prime search (one remainder per trial divisor)
// runs first; if the prime found fits in MAX_SLOTS, every old slot is then read and
// each stored key is reinserted with its own remainder and probe. After reset and
// after each write of initial_size (there after the prime search for the new
// capacity), a clearing pass over all MAX_SLOTS slots sweeps both banks while no
// item is accepted.
module linear_probe_hash_insert_rehash #(
	parameter int MAX_SLOTS = lphi_pkg::MAX_SLOTS_DEF,
	parameter int KEY_BITS = lphi_pkg::KEY_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lphi_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [30:0]                 key,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [9:0]                  slot_index,
	output logic [9:0]                  table_capacity,
	output logic                        did_rehash,
	output logic                        status
);
	import lphi_pkg::*;

	localparam int KW = (KEY_BITS < 31) ? KEY_BITS : 31;
	localparam int SW = $clog2(MAX_SLOTS);
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int NW0 = $clog2(2 * MAX_SLOTS) + 2;
	localparam int NW = (NW0 > 10) ? NW0 : 10;
	localparam int DW = (KW > NW) ? KW : NW;
	localparam int DCW = $clog2(DW + 1);
	localparam int LW = CW + 7;

	typedef enum logic [14:0] {
		S_CLEAR   = 15'b000000000000001,
		S_IDLE    = 15'b000000000000010,
		S_LOAD    = 15'b000000000000100,
		S_PRM_TST = 15'b000000000001000,
		S_PRM_SQ  = 15'b000000000010000,
		S_PRM_DIV = 15'b000000000100000,
		S_PRM_END = 15'b000000001000000,
		S_RH_RD   = 15'b000000010000000,
		S_RH_CHK  = 15'b000000100000000,
		S_RH_DIV  = 15'b000001000000000,
		S_HOME    = 15'b000010000000000,
		S_IN_DIV  = 15'b000100000000000,
		S_PR_RD   = 15'b001000000000000,
		S_PR_CHK  = 15'b010000000000000,
		S_OUT     = 15'b100000000000000
	} state_t;

	typedef enum logic [1:0] {
		P_INIT_UP = 2'd0,
		P_INIT_DN = 2'd1,
		P_GROW    = 2'd2
	} purpose_t;

	state_t state_q;
	purpose_t purp_q;
	logic [7:0] init_q;
	logic [6:0] load_q;
	logic [CW-1:0] cap_q, newcap_q, capn_q, cnt_q, clr_q, ri_q, tries_q;
	logic bank_q, tgt_q, rh_q, grew_q;
	logic [KW-1:0] key_q, pkey_q;
	logic [SW-1:0] pos_q;
	logic [NW-1:0] cand_q, d_q;
	logic [DW-1:0] div_dvd_q;
	logic [NW-1:0] div_dvs_q, div_rem_q;
	logic [DCW-1:0] div_cnt_q;
	logic div_run_q;
	logic [NW:0] rsh;
	logic [2*NW-1:0] dsq;
	logic [LW-1:0] lhs, rhs;
	logic out_valid_q, grew_out_q, stat_q;
	logic [9:0] slot_q, capo_q;
	logic [9:0] res_slot_q;
	logic res_stat_q;
	logic cfg_wr;
	logic cfg_idx;

	logic [KW:0] mem_a [MAX_SLOTS];
	logic [KW:0] mem_b [MAX_SLOTS];
	logic [KW:0] rd_a_q, rd_b_q, rd_src, rd_tgt, wd;
	logic [SW-1:0] ra, wa;
	logic we_a, we_b;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign cfg_idx = paddr[2];
	always_comb begin
		unique case (cfg_idx)
			REG_INIT_SIZE: prdata = {24'd0, init_q};
			REG_LOAD_PCT:  prdata = {25'd0, load_q};
			default:       prdata = '0;
		endcase
	end

	assign in_stall = (state_q != S_IDLE) | cfg_wr;
	assign out_valid = out_valid_q;
	assign slot_index = slot_q;
	assign table_capacity = capo_q;
	assign did_rehash = grew_out_q;
	assign status = stat_q;

	assign rsh = {div_rem_q, div_dvd_q[DW-1]};
	assign dsq = d_q * d_q;
	assign lhs = LW'(cnt_q) * LW'(LOAD_SCALE);
	assign rhs = LW'(load_q) * LW'(cap_q);
	assign rd_src = bank_q ? rd_b_q : rd_a_q;
	assign rd_tgt = tgt_q ? rd_b_q : rd_a_q;

	always_comb begin
		ra = (state_q == S_RH_RD) ? ri_q[SW-1:0] : pos_q;
		wa = pos_q;
		wd = '0;
		we_a = 1'b0;
		we_b = 1'b0;
		if (state_q == S_CLEAR) begin
			wa = clr_q[SW-1:0];
			we_a = 1'b1;
			we_b = 1'b1;
		end else if (state_q == S_RH_CHK) begin
			wa = ri_q[SW-1:0];
			we_a = !bank_q;
			we_b = bank_q;
		end else if (state_q == S_PR_CHK && !rd_tgt[KW]) begin
			wd = {1'b1, pkey_q};
			we_a = !tgt_q;
			we_b = tgt_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we_a) begin
			mem_a[wa] <= wd;
		end
		if (we_b) begin
			mem_b[wa] <= wd;
		end
		rd_a_q <= mem_a[ra];
		rd_b_q <= mem_b[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			purp_q <= P_INIT_UP;
			init_q <= INIT_SIZE_RST;
			load_q <= LOAD_PCT_RST;
			cap_q <= CW'(3);
			cnt_q <= '0;
			clr_q <= '0;
			bank_q <= 1'b0;
			div_run_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (div_run_q) begin
				if (rsh >= {1'b0, div_dvs_q}) begin
					div_rem_q <= NW'(rsh - {1'b0, div_dvs_q});
				end else begin
					div_rem_q <= rsh[NW-1:0];
				end
				div_dvd_q <= div_dvd_q << 1;
				div_cnt_q <= div_cnt_q - DCW'(1);
				if (div_cnt_q == DCW'(1)) begin
					div_run_q <= 1'b0;
				end
			end
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == CW'(MAX_SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid && !cfg_wr) begin
						key_q <= key[KW-1:0];
						grew_q <= 1'b0;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (lhs >= rhs) begin
						cand_q <= NW'({cap_q, 1'b1});
						purp_q <= P_GROW;
						state_q <= S_PRM_TST;
					end else begin
						state_q <= S_HOME;
					end
				end
				S_PRM_TST: begin
					if (cand_q < NW'(2)) begin
						if (purp_q == P_INIT_DN) begin
							state_q <= S_PRM_END;
						end else begin
							cand_q <= cand_q + NW'(2);
						end
					end else if (cand_q < NW'(4)) begin
						state_q <= S_PRM_END;
					end else if (!cand_q[0]) begin
						if (purp_q == P_INIT_DN) begin
							cand_q <= cand_q - NW'(1);
						end else begin
							cand_q <= cand_q + NW'(2);
						end
					end else begin
						d_q <= NW'(3);
						state_q <= S_PRM_SQ;
					end
				end
				S_PRM_SQ: begin
					if (dsq > (2*NW)'(cand_q)) begin
						state_q <= S_PRM_END;
					end else begin
						div_dvd_q <= DW'(cand_q);
						div_dvs_q <= d_q;
						div_rem_q <= '0;
						div_cnt_q <= DCW'(DW);
						div_run_q <= 1'b1;
						state_q <= S_PRM_DIV;
					end
				end
				S_PRM_DIV: begin
					if (!div_run_q) begin
						if (div_rem_q == '0) begin
							if (purp_q == P_INIT_DN) begin
								cand_q <= cand_q - NW'(1);
							end else begin
								cand_q <= cand_q + NW'(2);
							end
							state_q <= S_PRM_TST;
						end else begin
							d_q <= d_q + NW'(2);
							state_q <= S_PRM_SQ;
						end
					end
				end
				S_PRM_END: begin
					case (purp_q)
						P_INIT_UP: begin
							if (cand_q > NW'(MAX_SLOTS)) begin
								cand_q <= NW'(MAX_SLOTS);
								purp_q <= P_INIT_DN;
								state_q <= S_PRM_TST;
							end else begin
								cap_q <= CW'(cand_q);
								clr_q <= '0;
								state_q <= S_CLEAR;
							end
						end
						P_INIT_DN: begin
							cap_q <= CW'(cand_q);
							clr_q <= '0;
							state_q <= S_CLEAR;
						end
						default: begin
							if (cand_q > NW'(MAX_SLOTS)) begin
								state_q <= S_HOME;
							end else begin
								newcap_q <= CW'(cand_q);
								ri_q <= '0;
								state_q <= S_RH_RD;
							end
						end
					endcase
				end
				S_RH_RD: begin
					if (ri_q == cap_q) begin
						cap_q <= newcap_q;
						bank_q <= !bank_q;
						grew_q <= 1'b1;
						state_q <= S_HOME;
					end else begin
						state_q <= S_RH_CHK;
					end
				end
				S_RH_CHK: begin
					if (rd_src[KW]) begin
						pkey_q <= rd_src[KW-1:0];
						div_dvd_q <= DW'(rd_src[KW-1:0]);
						div_dvs_q <= NW'(newcap_q);
						div_rem_q <= '0;
						div_cnt_q <= DCW'(DW);
						div_run_q <= 1'b1;
						state_q <= S_RH_DIV;
					end else begin
						ri_q <= ri_q + CW'(1);
						state_q <= S_RH_RD;
					end
				end
				S_RH_DIV: begin
					if (!div_run_q) begin
						pos_q <= SW'(div_rem_q);
						tries_q <= '0;
						tgt_q <= !bank_q;
						capn_q <= newcap_q;
						rh_q <= 1'b1;
						state_q <= S_PR_RD;
					end
				end
				S_HOME: begin
					pkey_q <= key_q;
					div_dvd_q <= DW'(key_q);
					div_dvs_q <= NW'(cap_q);
					div_rem_q <= '0;
					div_cnt_q <= DCW'(DW);
					div_run_q <= 1'b1;
					state_q <= S_IN_DIV;
				end
				S_IN_DIV: begin
					if (!div_run_q) begin
						pos_q <= SW'(div_rem_q);
						tries_q <= '0;
						tgt_q <= bank_q;
						capn_q <= cap_q;
						rh_q <= 1'b0;
						state_q <= S_PR_RD;
					end
				end
				S_PR_RD: begin
					state_q <= S_PR_CHK;
				end
				S_PR_CHK: begin
					if (rd_tgt[KW]) begin
						if (tries_q == capn_q - CW'(1)) begin
							res_slot_q <= '0;
							res_stat_q <= STATUS_FULL;
							state_q <= S_OUT;
						end else begin
							tries_q <= tries_q + CW'(1);
							if (CW'(pos_q) == capn_q - CW'(1)) begin
								pos_q <= '0;
							end else begin
								pos_q <= pos_q + SW'(1);
							end
							state_q <= S_PR_RD;
						end
					end else if (rh_q) begin
						ri_q <= ri_q + CW'(1);
						state_q <= S_RH_RD;
					end else begin
						cnt_q <= cnt_q + CW'(1);
						res_slot_q <= 10'(pos_q);
						res_stat_q <= STATUS_STORED;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						slot_q <= res_slot_q;
						stat_q <= res_stat_q;
						capo_q <= 10'(cap_q);
						grew_out_q <= grew_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg_wr) begin
				if (cfg_idx == REG_INIT_SIZE) begin
					init_q <= pwdata[7:0];
					cand_q <= (pwdata[7:0] < 8'd2) ? NW'(3) : NW'({pwdata[7:0], 1'b1});
					purp_q <= P_INIT_UP;
					cnt_q <= '0;
					bank_q <= 1'b0;
					state_q <= S_PRM_TST;
				end else begin
					load_q <= pwdata[6:0];
				end
			end
		end
	end

	a_count_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cap_q)
		else $error("stored count exceeds capacity");
	a_cap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cap_q >= CW'(3)) && (CW'(cap_q) <= CW'(MAX_SLOTS)))
		else $error("capacity out of range");
	a_full_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && stat_q == STATUS_FULL) |-> (slot_q == '0 && !grew_out_q))
		else $error("rejected item carries a slot or growth");
	a_probe_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PR_CHK) |-> $past(state_q) == S_PR_RD)
		else $error("probe check without a preceding read");
endmodule
